@@ hdl/codec_playback_sample_unpacker_macros.svh @@
// Assertion macros shared by the checker of the playback sample unpacker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef CODEC_PLAYBACK_SAMPLE_UNPACKER_MACROS_SVH
`define CODEC_PLAYBACK_SAMPLE_UNPACKER_MACROS_SVH

// same-cycle implication, off during reset
`define CPSU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CPSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked during reset too
`define CPSU_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cpsu_pkg.sv @@
// Package for the playback sample unpacker: payload types, codes, constants,
// sample decode functions and the gain table generator. No dependencies.
`timescale 1ns / 1ps

package cpsu_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STEREO      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODING      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MUTE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_ATTEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MUTE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ATTEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_BASE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IRQ_ENABLE  = 3'd7;

    // sample coding; 5..7 are reserved
    localparam logic [2:0] CODING_PCM8    = 3'd0;
    localparam logic [2:0] CODING_MULAW   = 3'd1;
    localparam logic [2:0] CODING_PCM16LE = 3'd2;
    localparam logic [2:0] CODING_ALAW    = 3'd3;
    localparam logic [2:0] CODING_PCM16BE = 3'd4;

    localparam logic [15:0] MULAW_BIAS    = 16'h0084;
    localparam logic [7:0]  ALAW_XOR      = 8'h55;
    localparam logic [15:0] ALAW_SEG_BIAS = 16'h0108;
    localparam logic [15:0] ALAW_HALF_LSB = 16'h0008;

    localparam int  GAIN_ENTRIES  = 64;
    // amplitude factor per attenuation step is 10^-0.15 (3 dB units)
    localparam real GAIN_EXP_STEP = 0.15;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               irq_pending;
        logic               irq_raised;
    } t_out_item;

    // elaboration only: floor(2^frac_bits * 10^(-0.15*idx))
    function automatic int unsigned gain_entry(int frac_bits, int idx);
        real r;
        r = (2.0 ** frac_bits) * (10.0 ** (-GAIN_EXP_STEP * idx));
        return $rtoi(r);
    endfunction

    function automatic logic signed [15:0] decode_mulaw(logic [7:0] b);
        logic [7:0]  nb;
        logic [7:0]  mant;
        logic [15:0] t;
        nb   = ~b;
        mant = {1'b0, nb[3:0], 3'b000} + MULAW_BIAS[7:0];
        t    = {8'h00, mant} << nb[6:4];
        return nb[7] ? $signed(MULAW_BIAS - t) : $signed(t - MULAW_BIAS);
    endfunction

    function automatic logic signed [15:0] decode_alaw(logic [7:0] b);
        logic [7:0]  nb;
        logic [15:0] d;
        nb = b ^ ALAW_XOR;
        d  = {8'h00, nb[3:0], 4'h0};
        if (nb[6:4] == 3'd0) begin
            d = d | ALAW_HALF_LSB;
        end else begin
            d = (d | ALAW_SEG_BIAS) << (nb[6:4] - 3'd1);
        end
        return nb[7] ? $signed(d) : $signed(16'h0000 - d);
    endfunction

    // b0 is the first byte of the channel in the stream
    function automatic logic signed [15:0] decode_channel(logic [2:0] coding,
                                                          logic [7:0] b0,
                                                          logic [7:0] b1);
        logic signed [15:0] s;
        unique case (coding)
            CODING_PCM8:    s = $signed({~b0[7], b0[6:0], 8'h00}); // minus 0x80, times 256
            CODING_MULAW:   s = decode_mulaw(b0);
            CODING_PCM16LE: s = $signed({b1, b0});
            CODING_ALAW:    s = decode_alaw(b0);
            default:        s = $signed({b0, b1});
        endcase
        return s;
    endfunction

endpackage

@@ hdl/codec_playback_sample_unpacker.sv @@
// Playback sample unpacker: byte gathering, G.711 / PCM decode, channel gain,
// frame counter and sticky interrupt flag. Depends on cpsu_pkg.
`timescale 1ns / 1ps
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------
//  in      | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//  out     | o_out_valid / i_out_stall| o_out_data (t_out_item)
//  cfg     | i_cfg_wr_en              | i_cfg_idx, i_cfg_data
//
//  One byte or acknowledge per cycle while o_in_stall is low. A frame's result
//  passes from its last byte into the frame register, then through decode and
//  gain multiply into the output register.
//  Reset is synchronous; frame_count loads from count_base (0) at reset.
//  o_in_stall is high only when both the frame and output registers hold a
//  transaction and the output is stalled.

module codec_playback_sample_unpacker
    import cpsu_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    localparam int GAIN_W = GAIN_FRAC_BITS + 1;
    localparam int PROD_W = 16 + GAIN_W + 1;

    // configuration
    logic        r_stereo;
    logic [2:0]  r_coding;
    logic        r_left_mute;
    logic [5:0]  r_left_atten;
    logic        r_right_mute;
    logic [5:0]  r_right_atten;
    logic [15:0] r_count_base;
    logic        r_irq_enable;

    // frame state
    logic [1:0]         r_byte_phase, n_byte_phase;
    logic [23:0]        r_held_bytes, n_held_bytes;
    logic signed [16:0] r_frame_count, n_frame_count;
    logic               r_irq_flag, n_irq_flag;

    // frame register
    logic        r_s1_valid;
    logic [31:0] r_s1_bytes;
    logic        r_s1_pending;
    logic        r_s1_raised;

    // output register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic        in_acc;
    logic        out_ready;
    logic        s1_ready;
    logic        coding_ok;
    logic        wide;
    logic [2:0]  frame_len;
    logic [2:0]  phase_inc;
    logic [1:0]  last_idx;
    logic        frame_done;
    logic        push;
    logic [31:0] frame_bytes;
    logic signed [16:0] fc_base;
    logic        set_flag;
    logic        n_pending;
    logic        n_raised;

    logic [GAIN_W-1:0]  w_gain_rom [GAIN_ENTRIES];
    logic signed [15:0] left_dec, right_dec;
    logic signed [PROD_W-1:0] left_prod, right_prod;
    t_out_item          n_out_data;

    for (genvar a = 0; a < GAIN_ENTRIES; a++) begin : g_gain
        assign w_gain_rom[a] = GAIN_W'(gain_entry(GAIN_FRAC_BITS, a));
    end

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign s1_ready    = !r_s1_valid || out_ready;
    assign o_in_stall  = !s1_ready;
    assign in_acc      = i_in_valid && s1_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // byte gathering and frame counter, resolved at accept time
    always_comb begin
        coding_ok   = (r_coding <= CODING_PCM16BE);
        wide        = (r_coding == CODING_PCM16LE) || (r_coding == CODING_PCM16BE);
        frame_len   = wide ? (r_stereo ? 3'd4 : 3'd2) : (r_stereo ? 3'd2 : 3'd1);
        phase_inc   = {1'b0, r_byte_phase} + 3'd1;
        last_idx    = 2'(frame_len - 3'd1);
        frame_done  = (phase_inc >= frame_len);
        push        = in_acc && !i_in_data.func && coding_ok && frame_done;

        frame_bytes = {8'h00, r_held_bytes};
        frame_bytes[8*last_idx +: 8] = i_in_data.data_byte;

        fc_base       = r_frame_count[16] ? $signed({1'b0, r_count_base}) : r_frame_count;
        set_flag      = r_frame_count[16] && !r_irq_flag;
        n_pending     = r_irq_flag || set_flag;
        n_raised      = set_flag && r_irq_enable;

        n_byte_phase  = r_byte_phase;
        n_held_bytes  = r_held_bytes;
        n_frame_count = r_frame_count;
        n_irq_flag    = r_irq_flag;
        if (in_acc) begin
            if (i_in_data.func) begin
                n_irq_flag = 1'b0;
            end else if (coding_ok) begin
                if (frame_done) begin
                    n_byte_phase  = 2'd0;
                    n_held_bytes  = 24'h000000;
                    n_frame_count = fc_base - 17'sd1;
                    n_irq_flag    = n_pending;
                end else begin
                    n_byte_phase = phase_inc[1:0];
                    n_held_bytes[8*r_byte_phase +: 8] = i_in_data.data_byte;
                end
            end
        end
        // a count_base write also reloads the counter
        if (i_cfg_wr_en && (i_cfg_idx == REG_COUNT_BASE)) begin
            n_frame_count = $signed({1'b0, i_cfg_data});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo      <= 1'b0;
            r_coding      <= CODING_PCM8;
            r_left_mute   <= 1'b1;
            r_left_atten  <= 6'd0;
            r_right_mute  <= 1'b1;
            r_right_atten <= 6'd0;
            r_count_base  <= 16'd0;
            r_irq_enable  <= 1'b0;
            r_byte_phase  <= 2'd0;
            r_held_bytes  <= 24'h000000;
            r_frame_count <= 17'sd0;
            r_irq_flag    <= 1'b0;
        end else begin
            r_byte_phase  <= n_byte_phase;
            r_held_bytes  <= n_held_bytes;
            r_frame_count <= n_frame_count;
            r_irq_flag    <= n_irq_flag;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    REG_STEREO:      r_stereo      <= i_cfg_data[0];
                    REG_CODING:      r_coding      <= i_cfg_data[2:0];
                    REG_LEFT_MUTE:   r_left_mute   <= i_cfg_data[0];
                    REG_LEFT_ATTEN:  r_left_atten  <= i_cfg_data[5:0];
                    REG_RIGHT_MUTE:  r_right_mute  <= i_cfg_data[0];
                    REG_RIGHT_ATTEN: r_right_atten <= i_cfg_data[5:0];
                    REG_COUNT_BASE:  r_count_base  <= i_cfg_data;
                    REG_IRQ_ENABLE:  r_irq_enable  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // frame register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= push;
        end
        if (s1_ready && push) begin
            r_s1_bytes   <= frame_bytes;
            r_s1_pending <= n_pending;
            r_s1_raised  <= n_raised;
        end
    end

    // decode and gain
    always_comb begin
        left_dec = decode_channel(r_coding, r_s1_bytes[7:0], r_s1_bytes[15:8]);
        if (!r_stereo) begin
            right_dec = left_dec;
        end else if (wide) begin
            right_dec = decode_channel(r_coding, r_s1_bytes[23:16], r_s1_bytes[31:24]);
        end else begin
            right_dec = decode_channel(r_coding, r_s1_bytes[15:8], r_s1_bytes[23:16]);
        end
        left_prod  = left_dec * $signed({1'b0, w_gain_rom[r_left_atten]});
        right_prod = right_dec * $signed({1'b0, w_gain_rom[r_right_atten]});

        // arithmetic shift is floor for both signs
        n_out_data.left_sample  = r_left_mute ? 16'sd0 : left_prod[GAIN_FRAC_BITS +: 16];
        n_out_data.right_sample = r_right_mute ? 16'sd0 : right_prod[GAIN_FRAC_BITS +: 16];
        n_out_data.irq_pending  = r_s1_pending;
        n_out_data.irq_raised   = r_s1_raised;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
        if (out_ready && r_s1_valid) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

@@ hdl/cpsu_checker.sv @@
// Port-level checker for the playback sample unpacker, bound to the top level.
// Depends on cpsu_pkg and codec_playback_sample_unpacker_macros.svh.
`timescale 1ns / 1ps
`include "codec_playback_sample_unpacker_macros.svh"

module cpsu_checker
    import cpsu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a held result keeps its transaction until taken
    `CPSU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // input backs up only behind a stalled, full output
    `CPSU_ASSERT_SAME(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled without output backpressure")

    // a raised interrupt always reports the flag set
    `CPSU_ASSERT_SAME(a_raised_pending, o_out_valid && o_out_data.irq_raised, o_out_data.irq_pending, "irq raised without pending flag")

    `CPSU_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind codec_playback_sample_unpacker cpsu_checker u_cpsu_checker (.*);
